// ===== rtl/atkbf_pkg.sv =====
// Shared types and constants of the adaptive top-k bin filter.
package atkbf_pkg;

    // Fixed field widths.
    localparam int SCORE_W    = 16;
    localparam int TAG_W      = 16;
    localparam int SCALE_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int BIN_OUT_W  = 7;
    localparam int DIFF_W     = SCORE_W + 1;
    localparam int PROD_W     = SCORE_W + SCALE_W;
    localparam int FRAC_SHIFT = 23;
    localparam int BIN_FULL_W = PROD_W - FRAC_SHIFT;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd25600;
    localparam logic [COUNT_W-1:0] CAP_RESET   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          row_index;
        logic [TAG_W-1:0]          column_index;
    } t_in_item;

    typedef struct packed {
        logic                 accepted;
        logic [BIN_OUT_W-1:0] bin_index;
        logic [BIN_OUT_W-1:0] bottom_bin;
        logic [COUNT_W-1:0]   live_total;
        logic                 overflow;
        logic [TAG_W-1:0]     row_tag;
        logic [TAG_W-1:0]     column_tag;
    } t_out_item;

    typedef struct packed {
        logic                      top_k_mode;
        logic signed [SCORE_W-1:0] start_threshold;
        logic [SCALE_W-1:0]        bin_scale;
        logic [COUNT_W-1:0]        keep_goal;
        logic [COUNT_W-1:0]        capacity;
    } t_cfg;

    // Binner result handed to the sequencer.
    typedef struct packed {
        logic                  neg;
        logic [BIN_FULL_W-1:0] bin;
    } t_bin_res;

    // Decision fields produced by the sequencer.
    typedef struct packed {
        logic                 accepted;
        logic [BIN_OUT_W-1:0] bin_index;
        logic [BIN_OUT_W-1:0] bottom_bin;
        logic [COUNT_W-1:0]   live_total;
        logic                 overflow;
    } t_decision;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_INC,
        ST_ADV_RD,
        ST_ADV_CHK,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/atkbf_in_if.sv =====
// Request channel carrying one scored pair.
interface atkbf_in_if;
    import atkbf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/atkbf_out_if.sv =====
// Result channel carrying one decision tag.
interface atkbf_out_if;
    import atkbf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/atkbf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module atkbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/atkbf_binner.sv =====
// Score offset and bin scaling: a subtract stage followed by a multiply stage.
module atkbf_binner (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic signed [atkbf_pkg::SCORE_W-1:0] i_score,
    input  logic signed [atkbf_pkg::SCORE_W-1:0] i_start,
    input  logic [atkbf_pkg::SCALE_W-1:0]       i_scale,
    output atkbf_pkg::t_bin_res                 o_res
);
    import atkbf_pkg::*;

    logic signed [DIFF_W-1:0] r_diff;
    logic [PROD_W-1:0]        r_prod;

    // Offset from the start threshold, captured when a request is taken.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= DIFF_W'(i_score) - DIFF_W'(i_start);
        end
    end

    // Scale by the Q1.23 bin factor; a non-negative offset fits in 16 bits.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_diff[SCORE_W-1:0]) * PROD_W'(i_scale);
    end

    assign o_res.neg = r_diff[DIFF_W-1];
    assign o_res.bin = r_prod[PROD_W-1:FRAC_SHIFT];
endmodule

// ===== rtl/atkbf_seq.sv =====
// Sequencer: decides each request and does read-modify-write on the bin counts.
module atkbf_seq #(
    parameter int NUM_BINS = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  atkbf_pkg::t_cfg                i_cfg,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    output logic                           o_load,
    input  atkbf_pkg::t_bin_res            i_bin,
    output logic                           o_ram_we,
    output logic [$clog2(NUM_BINS)-1:0]    o_ram_waddr,
    output logic [atkbf_pkg::COUNT_W-1:0]  o_ram_wdata,
    output logic [$clog2(NUM_BINS)-1:0]    o_ram_raddr,
    input  logic [atkbf_pkg::COUNT_W-1:0]  i_ram_rdata,
    input  logic                           i_slot_free,
    output logic                           o_done,
    output atkbf_pkg::t_decision           o_dec
);
    import atkbf_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [BIN_FULL_W-1:0] NUM_BINS_F = BIN_FULL_W'(NUM_BINS);

    t_state r_state, n_state;
    logic [BIN_W-1:0]      r_clr, n_clr;
    logic [COUNT_W-1:0]    r_kept, n_kept;
    logic [BIN_W-1:0]      r_lowest, n_lowest;
    logic                  r_ovf, n_ovf;
    logic                  r_acc, n_acc;
    logic [BIN_FULL_W-1:0] r_bin, n_bin;

    logic                  w_ok;
    logic                  w_in_range;
    logic [COUNT_W-1:0]    w_rem;
    logic [BIN_FULL_W-1:0] w_lowest_f;

    assign w_lowest_f = BIN_FULL_W'(r_lowest);
    assign w_in_range = (i_bin.bin < NUM_BINS_F) && (i_bin.bin >= w_lowest_f);
    assign w_ok       = !i_bin.neg && !r_ovf && (!i_cfg.top_k_mode || w_in_range);
    assign w_rem      = r_kept - i_ram_rdata;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_kept   <= '0;
            r_lowest <= '0;
            r_ovf    <= 1'b0;
            r_acc    <= 1'b0;
            r_bin    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_kept   <= n_kept;
            r_lowest <= n_lowest;
            r_ovf    <= n_ovf;
            r_acc    <= n_acc;
            r_bin    <= n_bin;
        end
    end

    // Next state and memory access.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_kept      = r_kept;
        n_lowest    = r_lowest;
        n_ovf       = r_ovf;
        n_acc       = r_acc;
        n_bin       = r_bin;
        o_req_ready = 1'b0;
        o_load      = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_lowest;
        o_ram_wdata = '0;
        o_ram_raddr = r_lowest;
        o_done      = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == LAST_BIN) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_load      = i_req_valid;
                if (i_req_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_ram_raddr = i_bin.bin[BIN_W-1:0];
                n_acc       = 1'b0;
                n_bin       = '0;
                n_state     = ST_DONE;
                if (w_ok && r_kept >= i_cfg.capacity) begin
                    n_ovf = 1'b1;
                end else if (w_ok) begin
                    n_acc = 1'b1;
                    if (i_cfg.top_k_mode) begin
                        n_bin   = i_bin.bin;
                        n_state = ST_INC;
                    end else begin
                        n_kept = r_kept + 1'b1;
                    end
                end
            end
            ST_INC: begin
                // Count data for the chosen bin arrives this cycle.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_bin[BIN_W-1:0];
                o_ram_wdata = i_ram_rdata + 1'b1;
                n_kept      = r_kept + 1'b1;
                n_state     = ST_ADV_RD;
            end
            ST_ADV_RD: begin
                n_state = ST_ADV_CHK;
            end
            ST_ADV_CHK: begin
                // Empty the bottom bin while the rest still exceeds the goal.
                if (r_lowest < LAST_BIN && w_rem > i_cfg.keep_goal) begin
                    o_ram_we = 1'b1;
                    n_kept   = w_rem;
                    n_lowest = r_lowest + 1'b1;
                    n_state  = ST_ADV_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_dec.accepted   = r_acc;
    assign o_dec.bin_index  = r_bin[BIN_OUT_W-1:0];
    assign o_dec.bottom_bin = w_lowest_f[BIN_OUT_W-1:0];
    assign o_dec.live_total = r_kept;
    assign o_dec.overflow   = r_ovf;
endmodule

// ===== rtl/adaptive_top_k_bin_filter_core.sv =====
// Top level of the adaptive top-k bin filter.
//
// Requests arrive on i_in, one scored pair each (signed Q1.15 score, row and
// column). Each request yields exactly one tag on o_out: accept flag, bin,
// current bottom bin, live total, sticky overflow and the row and column.
// Both channels use valid/ready; a request or tag moves when both are high.
// Configuration registers are written through i_cfg_we, i_cfg_index and
// i_cfg_data; the user must write them only while no request is in flight,
// which the block does not enforce. Writes never clear state.
// The bin counts live in one memory of NUM_BINS words. A request passes
// through subtract, multiply and decide steps from acceptance to a decision.
// An accepted top-k request adds a read-modify-write of its bin, then a read
// and a check for each bottom-bin step and a last read and check; every
// request then hands its tag to the output register. One request is worked
// on at a time.
// After reset the memory is cleared one word a cycle; no request is taken
// until the clear is done. A stalled receiver holds the tag in the output
// register; the next request is still taken and waits for the register.
module adaptive_top_k_bin_filter_core #(
    parameter int NUM_BINS = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    atkbf_in_if.sink                               i_in,
    atkbf_out_if.source                            o_out,
    input  logic                                   i_cfg_we,
    input  logic [atkbf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [atkbf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import atkbf_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);

    t_cfg             r_cfg;
    logic [TAG_W-1:0] r_row, r_col;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_ready;
    logic             w_load;
    t_bin_res         w_bin;
    logic             w_ram_we;
    logic [BIN_W-1:0] w_ram_waddr;
    logic [BIN_W-1:0] w_ram_raddr;
    logic [COUNT_W-1:0] w_ram_wdata;
    logic [COUNT_W-1:0] w_ram_rdata;
    logic             w_slot_free;
    logic             w_done;
    t_decision        w_dec;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.top_k_mode      <= 1'b0;
            r_cfg.start_threshold <= '0;
            r_cfg.bin_scale       <= SCALE_RESET;
            r_cfg.keep_goal       <= '0;
            r_cfg.capacity        <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_cfg.top_k_mode      <= i_cfg_data[0];
                CFG_START: r_cfg.start_threshold <= i_cfg_data[SCORE_W-1:0];
                CFG_SCALE: r_cfg.bin_scale       <= i_cfg_data[SCALE_W-1:0];
                CFG_GOAL:  r_cfg.keep_goal       <= i_cfg_data[COUNT_W-1:0];
                CFG_CAP:   r_cfg.capacity        <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Tags of the request in flight.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_row <= i_in.data.row_index;
            r_col <= i_in.data.column_index;
        end
    end

    assign i_in.ready = w_ready;

    atkbf_binner u_binner (
        .i_clk   (i_clk),
        .i_load  (w_load),
        .i_score (i_in.data.score),
        .i_start (r_cfg.start_threshold),
        .i_scale (r_cfg.bin_scale),
        .o_res   (w_bin)
    );

    atkbf_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    atkbf_seq #(
        .NUM_BINS (NUM_BINS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_valid (i_in.valid),
        .o_req_ready (w_ready),
        .o_load      (w_load),
        .i_bin       (w_bin),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .i_slot_free (w_slot_free),
        .o_done      (w_done),
        .o_dec       (w_dec)
    );

    // Output register, freed when the receiver takes the tag.
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out.accepted   <= w_dec.accepted;
            r_out.bin_index  <= w_dec.bin_index;
            r_out.bottom_bin <= w_dec.bottom_bin;
            r_out.live_total <= w_dec.live_total;
            r_out.overflow   <= w_dec.overflow;
            r_out.row_tag    <= r_row;
            r_out.column_tag <= r_col;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

// ===== tb/sv/tb_adaptive_top_k_bin_filter_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive top-k bin filter core.
module tb_adaptive_top_k_bin_filter_core;
    import atkbf_pkg::*;

    localparam int NUM_BINS      = 128;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int IDLE_PERCENT  = 30;
    localparam int SCORE_MIN     = -32768;
    localparam int SCORE_MAX     = 32767;
    localparam int THRESH_ITEMS  = 200;
    localparam int BIN_ITEMS     = 200;
    localparam int ADVANCE_ITEMS = 150;
    localparam int MIX_BATCH     = 40;
    localparam logic MODE_THRESHOLD = 1'b0;
    localparam logic MODE_TOP_K     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    atkbf_in_if  req_if ();
    atkbf_out_if tag_if ();

    adaptive_top_k_bin_filter_core #(
        .NUM_BINS(NUM_BINS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_if),
        .o_out      (tag_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic                      mode_reg;
    logic signed [SCORE_W-1:0] start_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic [COUNT_W-1:0]        goal_reg;
    logic [COUNT_W-1:0]        cap_reg;

    // Shadow copy of the histogram and its totals.
    logic [COUNT_W-1:0] bin_count [NUM_BINS];
    logic [COUNT_W-1:0] kept_count;
    int                 bottom;
    logic               overflow_seen;

    t_out_item expected_tags [$];
    int        fail_count  = 0;
    int        cycle_count = 0;
    bit        no_idle     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the tag of one accepted request and updates the shadow state.
    function automatic t_out_item decide_pair(input t_in_item item);
        t_out_item tag;
        int        diff;
        longint    bin;
        logic      keep;
        diff = int'(signed'(item.score)) - int'(start_reg);
        keep = (diff >= 0) && !overflow_seen;
        bin  = 0;
        tag  = '0;
        if (keep && mode_reg) begin
            bin = (longint'(diff) * longint'(scale_reg)) >>> FRAC_SHIFT;
            if (bin >= NUM_BINS || bin < bottom) begin
                keep = 1'b0;
            end
        end
        if (keep && kept_count >= cap_reg) begin
            overflow_seen = 1'b1;
            keep = 1'b0;
        end
        if (keep) begin
            kept_count++;
            if (mode_reg) begin
                bin_count[bin]++;
                tag.bin_index = bin[BIN_OUT_W-1:0];
                // Empty the bottom bin while the rest still exceeds the goal.
                while (bottom < NUM_BINS - 1 && kept_count - bin_count[bottom] > goal_reg) begin
                    kept_count -= bin_count[bottom];
                    bin_count[bottom] = '0;
                    bottom++;
                end
            end
        end
        tag.accepted   = keep;
        tag.bottom_bin = bottom[BIN_OUT_W-1:0];
        tag.live_total = kept_count;
        tag.overflow   = overflow_seen;
        tag.row_tag    = item.row_index;
        tag.column_tag = item.column_index;
        return tag;
    endfunction

    // Items kept in threshold mode never leave the live total.
    function automatic logic [COUNT_W-1:0] pinned_total();
        logic [COUNT_W-1:0] sum;
        sum = '0;
        foreach (bin_count[i]) begin
            sum += bin_count[i];
        end
        return kept_count - sum;
    endfunction

    function automatic int random_score();
        return int'($urandom_range(0, 65535)) + SCORE_MIN;
    endfunction

    // Score that lands in the given bin under the current start and scale.
    function automatic int score_for_bin(input int target, input bit jitter);
        longint divisor;
        longint diff;
        longint score;
        divisor = (scale_reg == 0) ? 1 : longint'(scale_reg);
        diff = ((longint'(target) << FRAC_SHIFT) + divisor - 1) / divisor;
        if (jitter) begin
            diff += $urandom_range(0, 32'((longint'(1) << FRAC_SHIFT) / divisor));
        end
        score = longint'(start_reg) + diff;
        if (score > SCORE_MAX) begin
            score = SCORE_MAX;
        end
        return int'(score);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MODE:  mode_reg  = val[0];
            CFG_START: start_reg = val[SCORE_W-1:0];
            CFG_SCALE: scale_reg = val[SCALE_W-1:0];
            CFG_GOAL:  goal_reg  = val;
            CFG_CAP:   cap_reg   = val;
            default: ;
        endcase
    endtask

    // Sends one request after a random gap and records its expected tag.
    task automatic send_pair(input int score, input logic [TAG_W-1:0] row,
                             input logic [TAG_W-1:0] column);
        t_in_item item;
        item.score        = score[SCORE_W-1:0];
        item.row_index    = row;
        item.column_index = column;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge i_clk); while (!req_if.ready);
        expected_tags.push_back(decide_pair(item));
    endtask

    task automatic send_score(input int score);
        send_pair(score, TAG_W'($urandom()), TAG_W'($urandom()));
    endtask

    // Mostly scores aimed from three bins below the bottom bin upward, some anywhere.
    task automatic send_near_bottom();
        int low;
        low = (bottom > 3) ? bottom - 3 : 0;
        if ($urandom_range(0, 99) < 15) begin
            send_score(random_score());
        end else begin
            send_score(score_for_bin($urandom_range(low, NUM_BINS + 2), 1'b1));
        end
    endtask

    // Drops valid and waits until every tag has come back.
    task automatic wait_for_tags();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_tags.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic test_threshold_mode();
        // Scores at and just below the reset threshold and at both extremes, tags at both extremes.
        send_pair(0, '0, '0);
        send_pair(-1, '1, '1);
        send_pair(SCORE_MAX, 16'h5555, 16'hAAAA);
        send_pair(SCORE_MIN, 16'hAAAA, 16'h5555);
        wait_for_tags();
        write_reg(CFG_START, SCORE_MAX);
        send_score(SCORE_MAX);
        send_score(SCORE_MAX - 1);
        wait_for_tags();
        write_reg(CFG_START, SCORE_MIN);
        send_score(SCORE_MIN);
        send_score(SCORE_MAX);
        // Random scores against a new threshold every batch.
        for (int i = 0; i < THRESH_ITEMS; i++) begin
            if (i % 50 == 0) begin
                wait_for_tags();
                write_reg(CFG_START, $urandom_range(0, 65535));
            end
            send_score(random_score());
        end
        wait_for_tags();
    endtask

    task automatic test_bin_limits();
        write_reg(CFG_START, SCORE_MIN);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_TOP_K));
        write_reg(CFG_GOAL, pinned_total() + 2);
        // The fourth insert lifts the bottom past bin 0, which is then refused.
        send_score(score_for_bin(0, 1'b0));
        send_score(score_for_bin(1, 1'b0));
        send_score(score_for_bin(1, 1'b0));
        send_score(score_for_bin(2, 1'b0));
        send_score(score_for_bin(0, 1'b0));
        // Bins past the top are refused; the top bin itself is kept.
        send_score(SCORE_MAX);
        send_score(score_for_bin(NUM_BINS, 1'b0));
        send_score(score_for_bin(NUM_BINS - 1, 1'b0));
        wait_for_tags();
        write_reg(CFG_GOAL, '1);
        write_reg(CFG_SCALE, '0);
        send_score(SCORE_MAX);
        wait_for_tags();
        write_reg(CFG_SCALE, CFG_DATA_W'({SCALE_W{1'b1}}));
        send_score(SCORE_MIN + 64);
        send_score(SCORE_MIN + 65);
        // Random scale and start with the goal out of reach.
        for (int i = 0; i < BIN_ITEMS; i++) begin
            if (i % 40 == 0) begin
                wait_for_tags();
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(CFG_SCALE, $urandom_range(0, (1 << SCALE_W) - 1));
                end else begin
                    write_reg(CFG_SCALE, $urandom_range(8000, 60000));
                end
                write_reg(CFG_START, $urandom_range(0, 65535));
            end
            if ($urandom_range(0, 1) == 0) begin
                send_score(random_score());
            end else begin
                send_score(score_for_bin($urandom_range(0, NUM_BINS + 12), 1'b1));
            end
        end
        wait_for_tags();
    endtask

    task automatic test_bottom_advance();
        int windows [4] = '{300, 80, 20, 0};
        foreach (windows[w]) begin
            wait_for_tags();
            write_reg(CFG_SCALE, $urandom_range(20000, 60000));
            write_reg(CFG_START, SCORE_MIN + $urandom_range(0, 1000));
            write_reg(CFG_GOAL, pinned_total() + windows[w]);
            // One window runs with both sides streaming without a gap.
            no_idle = (w == 1);
            for (int i = 0; i < ADVANCE_ITEMS; i++) begin
                send_near_bottom();
            end
        end
        wait_for_tags();
        no_idle = 1'b0;
    endtask

    task automatic test_mode_switch();
        // Threshold items stay in the live total after going back to top-k.
        for (int b = 0; b < 5; b++) begin
            wait_for_tags();
            if (b % 2 == 0) begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_THRESHOLD));
            end else begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_TOP_K));
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(CFG_GOAL, pinned_total() + $urandom_range(10, 60));
                end
            end
            for (int i = 0; i < MIX_BATCH; i++) begin
                send_near_bottom();
            end
        end
        wait_for_tags();
    endtask

    task automatic test_unused_registers();
        for (int idx = int'(CFG_CAP) + 1; idx <= int'(CFG_LAST_INDEX); idx++) begin
            write_reg(CFG_IDX_W'(idx), $urandom());
        end
        for (int i = 0; i < 20; i++) begin
            send_near_bottom();
        end
        wait_for_tags();
    endtask

    task automatic test_capacity_overflow();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_THRESHOLD));
        write_reg(CFG_START, SCORE_MIN);
        write_reg(CFG_CAP, kept_count + $urandom_range(3, 8));
        // Every score passes, so the capacity is hit within a few requests.
        for (int i = 0; i < 12; i++) begin
            send_score(random_score());
        end
        wait_for_tags();
        // The flag is sticky whatever the capacity and mode become.
        write_reg(CFG_CAP, '0);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_TOP_K));
        for (int i = 0; i < 40; i++) begin
            send_near_bottom();
        end
        wait_for_tags();
        write_reg(CFG_CAP, '1);
        for (int i = 0; i < 40; i++) begin
            send_score(random_score());
        end
        wait_for_tags();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result side stalls at random unless idling is switched off.
    always @(negedge i_clk) begin
        tag_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Compares each delivered tag with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && tag_if.valid && tag_if.ready) begin
            if (expected_tags.size() == 0) begin
                $display("%0t: tag with no pending request, expected none actual %h",
                         $time, tag_if.data);
                fail_count++;
            end else begin
                want = expected_tags.pop_front();
                check_field("accepted", want.accepted, tag_if.data.accepted);
                check_field("bin_index", want.bin_index, tag_if.data.bin_index);
                check_field("bottom_bin", want.bottom_bin, tag_if.data.bottom_bin);
                check_field("live_total", want.live_total, tag_if.data.live_total);
                check_field("overflow", want.overflow, tag_if.data.overflow);
                check_field("row_tag", want.row_tag, tag_if.data.row_tag);
                check_field("column_tag", want.column_tag, tag_if.data.column_tag);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("adaptive_top_k_bin_filter_core: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_MODE;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        tag_if.ready = 1'b0;
        mode_reg      = MODE_THRESHOLD;
        start_reg     = '0;
        scale_reg     = SCALE_RESET;
        goal_reg      = '0;
        cap_reg       = CAP_RESET;
        kept_count    = '0;
        bottom        = 0;
        overflow_seen = 1'b0;
        foreach (bin_count[i]) begin
            bin_count[i] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_threshold_mode();
        test_bin_limits();
        test_bottom_advance();
        test_mode_switch();
        test_unused_registers();
        test_capacity_overflow();

        wait_for_tags();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("adaptive_top_k_bin_filter_core: match");
        end else begin
            $display("adaptive_top_k_bin_filter_core: mismatch");
        end
        $finish;
    end

endmodule
